[design/mmh_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none

package mmh_pkg;

   localparam logic [31:0] MIX_C1  = 32'hcc9e2d51;
   localparam logic [31:0] MIX_C2  = 32'h1b873593;
   localparam logic [31:0] MIX_ADD = 32'he6546b64;
   localparam logic [31:0] FIN_C1  = 32'h85ebca6b;
   localparam logic [31:0] FIN_C2  = 32'hc2b2ae35;

   localparam logic [2:0] BLOCK_BYTES = 3'd4;

   // register map, decoded on word address paddr[2]
   localparam logic CSR_SEED_IDX = 1'b0;

   // one classified word on its way from the front to the back
   typedef struct packed {
      logic [31:0] k;       // mixed key word
      logic [2:0]  count;   // bytes it adds to the key length, 0 to 4
      logic        block;   // full word: block mix
      logic        tail;    // partial last word: tail mix
      logic        last;    // closes the key
   } job_type;

   function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned r);
      rotl32 = (x << r) | (x >> (32 - r));
   endfunction

endpackage

`default_nettype wire

[design/mmh_front.sv]
`timescale 1ns / 1ps
`default_nettype none

module mmh_front (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  in_valid,
   output logic                 in_ready,
   input  wire  [31:0]          in_word,
   input  wire  [2:0]           in_count,
   input  wire                  in_last,
   output logic                 out_valid,
   input  wire                  out_ready,
   output mmh_pkg::job_type     out_job
);

   logic             s1_valid_ff, s1_valid_in;
   logic [31:0]      s1_prod_ff;
   logic [2:0]       s1_count_ff;
   logic             s1_block_ff, s1_tail_ff, s1_last_ff;
   logic             s2_valid_ff, s2_valid_in;
   mmh_pkg::job_type s2_job_ff;

   logic             accept, s1_adv, s2_ready;
   logic [2:0]       norm_count;
   logic             norm_block, norm_tail;
   logic [31:0]      masked;

   assign s2_ready = !s2_valid_ff || out_ready;
   assign s1_adv   = s1_valid_ff && s2_ready;
   assign in_ready = !s1_valid_ff || s2_ready;
   assign accept   = in_valid && in_ready;

   // classify: anything not last, or a count of four and up, is a full block
   always_comb begin
      if (!in_last || in_count >= mmh_pkg::BLOCK_BYTES) begin
         norm_count = mmh_pkg::BLOCK_BYTES;
         norm_block = 1'b1;
         norm_tail  = 1'b0;
      end else begin
         norm_count = in_count;
         norm_block = 1'b0;
         norm_tail  = (in_count != 3'd0);
      end
   end

   always_comb begin
      unique case (norm_count)
         3'd1:    masked = {24'd0, in_word[7:0]};
         3'd2:    masked = {16'd0, in_word[15:0]};
         3'd3:    masked = {8'd0, in_word[23:0]};
         default: masked = in_word;
      endcase
   end

   assign s1_valid_in = accept || (s1_valid_ff && !s2_ready);
   assign s2_valid_in = s1_adv || (s2_valid_ff && !out_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_prod_ff  <= masked * mmh_pkg::MIX_C1;
         s1_count_ff <= norm_count;
         s1_block_ff <= norm_block;
         s1_tail_ff  <= norm_tail;
         s1_last_ff  <= in_last;
      end
      if (s1_adv) begin
         s2_job_ff.k     <= mmh_pkg::rotl32(s1_prod_ff, 15) * mmh_pkg::MIX_C2;
         s2_job_ff.count <= s1_count_ff;
         s2_job_ff.block <= s1_block_ff;
         s2_job_ff.tail  <= s1_tail_ff;
         s2_job_ff.last  <= s1_last_ff;
      end
   end

   assign out_valid = s2_valid_ff;
   assign out_job   = s2_job_ff;

endmodule

`default_nettype wire

[design/mmh_queue.sv]
`timescale 1ns / 1ps
`default_nettype none

module mmh_queue #(
   parameter int DEPTH = 4
) (
   input  wire                  clock,
   input  wire                  reset,
   input  wire                  push_valid,
   output logic                 push_ready,
   input  mmh_pkg::job_type     push_job,
   output logic                 pop_valid,
   input  wire                  pop_ready,
   output mmh_pkg::job_type     pop_job
);

   localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   mmh_pkg::job_type  slot_ff [DEPTH];
   logic [IDX_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [IDX_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic              push, pop;

   assign push_ready = (count_ff != CNT_W'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;
   assign pop_job    = slot_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == IDX_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_job;
      end
   end

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(DEPTH))
      else $error("queue holds more transactions than its depth");

endmodule

`default_nettype wire

[design/mmh_back.sv]
`timescale 1ns / 1ps
`default_nettype none

module mmh_back (
   input  wire                  clock,
   input  wire                  reset,
   input  wire  [31:0]          seed,
   input  wire                  job_valid,
   output logic                 job_ready,
   input  mmh_pkg::job_type     job,
   output logic                 rsp_valid,
   input  wire                  rsp_ready,
   output logic [31:0]          rsp_hash
);

   typedef enum logic [3:0] {
      ST_ABSORB = 4'b0001,
      ST_FIN_A  = 4'b0010,
      ST_FIN_B  = 4'b0100,
      ST_FIN_C  = 4'b1000
   } back_state_type;

   back_state_type state_ff, state_in;
   logic [31:0]    h_ff, h_in;
   logic [31:0]    total_ff, total_in;
   logic           in_key_ff, in_key_in;
   logic [31:0]    fin_ff, fin_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [31:0]    rsp_hash_ff, rsp_hash_in;

   logic [31:0]    h_base, tot_base, mixed, rotated, absorbed, tot_next;
   logic           out_free, take;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign take     = job_valid && job_ready;

   always_comb begin
      h_base   = in_key_ff ? h_ff : seed;
      tot_base = in_key_ff ? total_ff : 32'd0;
      mixed    = h_base ^ job.k;
      rotated  = mmh_pkg::rotl32(mixed, 13);
      if (job.block) begin
         absorbed = (rotated << 2) + rotated + mmh_pkg::MIX_ADD;
      end else if (job.tail) begin
         absorbed = mixed;
      end else begin
         absorbed = h_base;
      end
      tot_next = tot_base + 32'(job.count);
   end

   always_comb begin
      state_in     = state_ff;
      h_in         = h_ff;
      total_in     = total_ff;
      in_key_in    = in_key_ff;
      fin_in       = fin_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_hash_in  = rsp_hash_ff;
      job_ready    = 1'b0;
      unique case (state_ff)
         ST_ABSORB: begin
            job_ready = 1'b1;
            if (job_valid) begin
               if (job.last) begin
                  fin_in    = absorbed ^ tot_next;
                  h_in      = 32'd0;
                  total_in  = 32'd0;
                  in_key_in = 1'b0;
                  state_in  = ST_FIN_A;
               end else begin
                  h_in      = absorbed;
                  total_in  = tot_next;
                  in_key_in = 1'b1;
               end
            end
         end
         ST_FIN_A: begin
            fin_in   = (fin_ff ^ (fin_ff >> 16)) * mmh_pkg::FIN_C1;
            state_in = ST_FIN_B;
         end
         ST_FIN_B: begin
            fin_in   = (fin_ff ^ (fin_ff >> 13)) * mmh_pkg::FIN_C2;
            state_in = ST_FIN_C;
         end
         ST_FIN_C: begin
            // hold until the output register is free
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_hash_in  = fin_ff ^ (fin_ff >> 16);
               state_in     = ST_ABSORB;
            end
         end
         default: begin
            state_in = ST_ABSORB;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_ABSORB;
         h_ff         <= 32'd0;
         total_ff     <= 32'd0;
         in_key_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         h_ff         <= h_in;
         total_ff     <= total_in;
         in_key_ff    <= in_key_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      fin_ff      <= fin_in;
      rsp_hash_ff <= rsp_hash_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_hash  = rsp_hash_ff;

   a_pop_only_absorb: assert property (@(posedge clock) disable iff (reset)
      take |-> state_ff == ST_ABSORB)
      else $error("transaction taken from queue outside absorb state");

   a_last_closes_key: assert property (@(posedge clock) disable iff (reset)
      take && job.last |=> !in_key_ff && state_ff == ST_FIN_A)
      else $error("last word did not close the key");

   a_fin_emits: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_FIN_C && out_free |=> rsp_valid_ff && state_ff == ST_ABSORB)
      else $error("finished hash not loaded into output register");

endmodule

`default_nettype wire

[design/murmur3_32_stream_hasher.sv]
`timescale 1ns / 1ps
`default_nettype none

// MurmurHash3 x86_32 over a key streamed as little-endian 32-bit words, first
// key byte in bits 7:0, one word per req transaction; req_last marks the final
// word and req_byte_count (0 to 4, higher taken as 4) its valid bytes, while
// earlier words always count as four bytes. One rsp transaction carrying the
// finished hash follows each last word. The front end masks and mixes each
// word in a two-stage multiplier pipeline and queues it; the back end folds
// a queued word into the running hash as it takes it, so words that do not end
// a key flow at one per cycle while the back end is absorbing. A last word holds
// the back end through absorb, two finalization multiplies and output load,
// and longer while the output register is still occupied; the queue keeps the
// front end accepting during that time until it fills. The seed register is
// sampled when the first word of a key reaches the back end.
module murmur3_32_stream_hasher #(
   parameter int QUEUE_DEPTH = 4
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_valid,
   output logic        req_ready,
   input  wire  [31:0] req_data_word,
   input  wire  [2:0]  req_byte_count,
   input  wire         req_last,
   output logic        rsp_valid,
   input  wire         rsp_ready,
   output logic [31:0] rsp_hash,
   input  wire         csr_psel,
   input  wire         csr_penable,
   input  wire         csr_pwrite,
   input  wire  [2:0]  csr_paddr,
   input  wire  [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [31:0]      seed_ff;
   logic             front_valid, front_ready;
   logic             queue_valid, queue_ready;
   mmh_pkg::job_type front_job, queue_job;

   assign csr_pready = 1'b1;
   assign csr_prdata = (csr_paddr[2] == mmh_pkg::CSR_SEED_IDX) ? seed_ff : 32'd0;

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= 32'd0;
      end else if (csr_psel && csr_penable && csr_pwrite
                   && csr_paddr[2] == mmh_pkg::CSR_SEED_IDX) begin
         seed_ff <= csr_pwdata;
      end
   end

   mmh_front u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_word   (req_data_word),
      .in_count  (req_byte_count),
      .in_last   (req_last),
      .out_valid (front_valid),
      .out_ready (front_ready),
      .out_job   (front_job)
   );

   mmh_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (front_valid),
      .push_ready (front_ready),
      .push_job   (front_job),
      .pop_valid  (queue_valid),
      .pop_ready  (queue_ready),
      .pop_job    (queue_job)
   );

   mmh_back u_back (
      .clock     (clock),
      .reset     (reset),
      .seed      (seed_ff),
      .job_valid (queue_valid),
      .job_ready (queue_ready),
      .job       (queue_job),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_hash  (rsp_hash)
   );

endmodule

`default_nettype wire

[dv/tb_murmur3_32_stream_hasher.sv]
`timescale 1ns / 1ps

module tb_murmur3_32_stream_hasher;

   localparam logic [31:0] K_MUL1  = 32'hcc9e2d51;
   localparam logic [31:0] K_MUL2  = 32'h1b873593;
   localparam logic [31:0] H_ADD   = 32'he6546b64;
   localparam logic [31:0] FIN_MUL1 = 32'h85ebca6b;
   localparam logic [31:0] FIN_MUL2 = 32'hc2b2ae35;

   localparam logic [2:0] SEED_ADDR   = 3'd0;
   localparam int         SETTLE      = 16;
   localparam int         HOLD_CYCLES = 300;
   localparam int         STALL_LIMIT = 4000;
   localparam int         CHUNK_ITEMS = 72;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [31:0] req_data_word = '0;
   logic [2:0]  req_byte_count = '0;
   logic        req_last = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_hash;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   murmur3_32_stream_hasher DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_word  (req_data_word),
      .req_byte_count (req_byte_count),
      .req_last       (req_last),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hash       (rsp_hash),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // hash predictor state
   logic [31:0] seed_shadow = '0;
   logic [31:0] key_hash    = '0;
   logic [31:0] key_bytes   = '0;
   logic        key_open    = 1'b0;
   logic [31:0] expected_hashes[$];

   int   error_count   = 0;
   int   sent_items    = 0;
   int   stalled_cycles = 0;
   bit   gaps_on       = 1'b1;
   logic rx_holding    = 1'b0;
   int   rx_stall_left = 0;
   logic [31:0] want_hash;
   event rx_hold_start;

   function automatic logic [31:0] rol32(input logic [31:0] x, input int r);
      return (x << r) | (x >> (32 - r));
   endfunction

   function automatic logic [31:0] k_mix(input logic [31:0] k);
      logic [31:0] m;
      m = k * K_MUL1;
      m = rol32(m, 15);
      m = m * K_MUL2;
      return m;
   endfunction

   function automatic logic [31:0] final_mix(input logic [31:0] h);
      logic [31:0] f;
      f = h ^ (h >> 16);
      f = f * FIN_MUL1;
      f = f ^ (f >> 13);
      f = f * FIN_MUL2;
      f = f ^ (f >> 16);
      return f;
   endfunction

   function automatic void hash_absorb(input logic [31:0] word, input logic [2:0] cnt,
                                       input logic lst);
      logic [31:0] h;
      logic [31:0] mask;
      logic [31:0] n;
      if (!key_open) begin
         key_hash  = seed_shadow;
         key_bytes = '0;
      end
      h = key_hash;
      if (!lst || cnt >= 3'd4) begin
         n = 32'd4;
         h = h ^ k_mix(word);
         h = rol32(h, 13);
         h = h * 32'd5 + H_ADD;
      end else begin
         n = {29'd0, cnt};
         if (cnt != 3'd0) begin
            mask = 32'hffffffff >> (8 * (4 - cnt));
            h = h ^ k_mix(word & mask);
         end
      end
      key_bytes = key_bytes + n;
      if (!lst) begin
         key_hash = h;
         key_open = 1'b1;
      end else begin
         expected_hashes.push_back(final_mix(h ^ key_bytes));
         key_hash  = '0;
         key_bytes = '0;
         key_open  = 1'b0;
      end
   endfunction

   function automatic logic [31:0] rand_word();
      case ($urandom_range(0, 9))
         0: return 32'h00000000;
         1: return 32'hffffffff;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_word(input logic [31:0] word, input logic [2:0] cnt, input logic lst);
      if (gaps_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_data_word  <= word;
      req_byte_count <= cnt;
      req_last       <= lst;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      hash_absorb(word, cnt, lst);
      sent_items++;
   endtask

   task automatic send_key(input int words, input logic [2:0] tail_cnt);
      for (int i = 0; i < words - 1; i++)
         send_word(rand_word(), 3'($urandom_range(0, 7)), 1'b0);
      send_word(rand_word(), tail_cnt, 1'b1);
   endtask

   // drop valid, wait for every hash, then let the back end settle
   task automatic drain();
      req_valid <= 1'b0;
      while (expected_hashes.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic program_seed(input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= SEED_ADDR;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      seed_shadow = value;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      if (csr_prdata !== seed_shadow) begin
         $error("seed readback: expected %08h actual %08h", seed_shadow, csr_prdata);
         error_count++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic test_directed_keys();
      gaps_on = 1'b1;
      // seed at its reset value
      send_word(32'h00000000, 3'd0, 1'b1);
      send_word(32'hffffffff, 3'd4, 1'b1);
      send_word(32'hffffffff, 3'd1, 1'b1);
      send_word(32'hffffffff, 3'd2, 1'b1);
      send_word(32'hffffffff, 3'd3, 1'b1);
      send_word(32'h12345678, 3'd5, 1'b1);
      send_word(32'h9abcdef0, 3'd6, 1'b1);
      send_word(32'h87654321, 3'd7, 1'b1);
      send_word(32'hffffffff, 3'd0, 1'b0);
      send_word(32'h00000000, 3'd4, 1'b1);
      send_word(32'ha5a5a5a5, 3'd7, 1'b0);
      send_word(32'h5a5a5a5a, 3'd2, 1'b0);
      send_word(32'hdeadbeef, 3'd3, 1'b1);
      send_word(32'hffffffff, 3'd1, 1'b0);
      send_word(32'hffffffff, 3'd0, 1'b1);
      drain();
      program_seed(32'hffffffff);
      send_word(32'h00000000, 3'd0, 1'b1);
      send_word(32'h00000000, 3'd4, 1'b1);
      send_word(32'hffffffff, 3'd3, 1'b1);
      send_word(32'h80000001, 3'd5, 1'b0);
      send_word(32'h7ffffffe, 3'd1, 1'b1);
      drain();
   endtask

   task automatic test_backpressure();
      gaps_on = 1'b0;
      program_seed($urandom);
      -> rx_hold_start;
      // keep offering single-word keys while the receiver holds off, then ten keys of two to four words
      for (int i = 0; i < 40; i++)
         send_word(rand_word(), 3'($urandom_range(0, 7)), 1'b1);
      for (int i = 0; i < 10; i++)
         send_key($urandom_range(2, 4), 3'($urandom_range(0, 7)));
      drain();
   endtask

   task automatic test_random_keys();
      int chunk_end;
      for (int c = 0; c < 5; c++) begin
         case (c)
            0: program_seed(32'h00000000);
            1: program_seed(32'hffffffff);
            default: program_seed($urandom);
         endcase
         // last chunk runs with no idling on either side
         gaps_on = (c != 4);
         chunk_end = sent_items + CHUNK_ITEMS;
         while (sent_items < chunk_end) begin
            if ($urandom_range(0, 9) == 0)
               send_key($urandom_range(5, 12), 3'($urandom_range(0, 7)));
            else
               send_key($urandom_range(1, 4), 3'($urandom_range(0, 7)));
         end
         drain();
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed_keys();
      test_backpressure();
      test_random_keys();
      repeat (20) @(posedge clock);
      if (error_count == 0 && expected_hashes.size() == 0)
         $display("ALL CHECKS PASSED");
      else
         $display("CHECKS FAILED");
      $finish;
   end

   always begin
      @(rx_hold_start);
      rx_holding <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clock);
      rx_holding <= 1'b0;
   end

   always @(posedge clock) begin
      if (rx_holding) begin
         rsp_ready <= 1'b0;
      end else if (rx_stall_left != 0) begin
         rsp_ready     <= 1'b0;
         rx_stall_left <= rx_stall_left - 1;
      end else if (gaps_on && $urandom_range(0, 5) == 0) begin
         rsp_ready     <= 1'b0;
         rx_stall_left <= $urandom_range(0, 4);
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_hashes.size() == 0) begin
            $error("hash: expected none actual %08h", rsp_hash);
            error_count++;
         end else begin
            want_hash = expected_hashes.pop_front();
            if (rsp_hash !== want_hash) begin
               $error("hash: expected %08h actual %08h", want_hash, rsp_hash);
               error_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_psel && csr_penable && csr_pready))
         stalled_cycles <= 0;
      else
         stalled_cycles <= stalled_cycles + 1;
      if (stalled_cycles >= STALL_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

endmodule

[sim.f]
design/mmh_pkg.sv
design/mmh_front.sv
design/mmh_queue.sv
design/mmh_back.sv
design/murmur3_32_stream_hasher.sv
dv/tb_murmur3_32_stream_hasher.sv
